// ===== hw/rtl/intel_hex_record_decoder_defines.svh =====
// Assertion macros used by the checker of the hex record decoder.
`ifndef INTEL_HEX_RECORD_DECODER_DEFINES_SVH
`define INTEL_HEX_RECORD_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while reset is asserted.
`define IHEX_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ihex check failed: same-cycle rule");

// Next-cycle implication, sampled on i_clk, off while reset is asserted.
`define IHEX_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ihex check failed: next-cycle rule");

`endif

// ===== hw/rtl/ihex_pkg.sv =====
// Types, character codes and field kinds shared by the hex record decoder.
`timescale 1ns / 1ps

package ihex_pkg;

    localparam logic [7:0] CHAR_COLON    = 8'h3A;
    localparam logic [7:0] CHAR_DIGIT_LO = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_HI = 8'h39;
    localparam logic [7:0] CHAR_UPPER_LO = 8'h41;
    localparam logic [7:0] CHAR_UPPER_HI = 8'h46;
    localparam logic [7:0] CHAR_LOWER_LO = 8'h61;
    localparam logic [7:0] CHAR_LOWER_HI = 8'h66;
    // 'A' - 10 and 'a' - 10
    localparam logic [7:0] UPPER_BIAS    = 8'h37;
    localparam logic [7:0] LOWER_BIAS    = 8'h57;

    localparam logic [7:0] EOF_CHECKSUM  = 8'hFF;
    localparam logic [7:0] EOF_TYPE      = 8'h01;

    typedef logic [2:0] t_kind;
    localparam t_kind KIND_COUNT    = 3'd0;
    localparam t_kind KIND_ADDR_HI  = 3'd1;
    localparam t_kind KIND_ADDR_LO  = 3'd2;
    localparam t_kind KIND_TYPE     = 3'd3;
    localparam t_kind KIND_DATA     = 3'd4;
    localparam t_kind KIND_CHECKSUM = 3'd5;

    // One queued item: either a record start or one hex digit.
    typedef struct packed {
        logic       is_colon;
        logic [3:0] nibble;
    } t_token;

    typedef struct packed {
        logic       hit;
        logic [3:0] nibble;
    } t_digit;

    function automatic t_digit hex_digit(input logic [7:0] c);
        t_digit     r;
        logic [7:0] v;
        r.hit = 1'b1;
        v     = 8'h00;
        if (c inside {[CHAR_DIGIT_LO:CHAR_DIGIT_HI]}) begin
            v = c - CHAR_DIGIT_LO;
        end else if (c inside {[CHAR_UPPER_LO:CHAR_UPPER_HI]}) begin
            v = c - UPPER_BIAS;
        end else if (c inside {[CHAR_LOWER_LO:CHAR_LOWER_HI]}) begin
            v = c - LOWER_BIAS;
        end else begin
            r.hit = 1'b0;
        end
        r.nibble = v[3:0];
        return r;
    endfunction

endpackage

// ===== hw/rtl/intel_hex_record_decoder.sv =====
// Intel HEX record decoder: top level.
//
// Input channel (i_valid / o_stall / i_character): one ASCII character per item.
// Output channel (o_valid / i_stall / o_*): one item per decoded byte, tagged with
// its field kind, the record address, the data offset and, on the checksum byte,
// the checksum and end-of-file flags.
// A classifier keeps colons and hex digits and writes them into a queue of
// QUEUE_DEPTH items; a record sequencer reads one item per cycle into a
// registered output stage whenever that stage is empty or being taken.
// Throughput: one character per clock while the output is not held by i_stall,
// set by the sequencer taking one queue item per cycle. A byte closed by a
// second digit passes through the queue and then the registered output stage.
// Reset clears the queue, the record state and the end-of-file state; after an
// end-of-file record all further characters are taken and dropped until reset.
// While i_stall is high a valid output holds; the queue takes up to QUEUE_DEPTH
// digits or colons, after which o_stall rises until the output is taken.
`timescale 1ns / 1ps

module intel_hex_record_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_character,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_byte_value,
    output logic [2:0]  o_field_kind,
    output logic [15:0] o_record_address,
    output logic [7:0]  o_data_offset,
    output logic        o_checksum_ok,
    output logic        o_end_of_file,
    output logic        o_record_end
);

    logic             w_push, w_full, w_q_valid, w_pop;
    ihex_pkg::t_token w_in_token, w_q_token;

    ihex_front u_front (
        .i_valid      (i_valid),
        .i_character  (i_character),
        .i_queue_full (w_full),
        .o_stall      (o_stall),
        .o_push       (w_push),
        .o_token      (w_in_token)
    );

    ihex_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_token (w_in_token),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_token (w_q_token)
    );

    ihex_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_token_valid    (w_q_valid),
        .i_token          (w_q_token),
        .o_token_pop      (w_pop),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_byte_value     (o_byte_value),
        .o_field_kind     (o_field_kind),
        .o_record_address (o_record_address),
        .o_data_offset    (o_data_offset),
        .o_checksum_ok    (o_checksum_ok),
        .o_end_of_file    (o_end_of_file),
        .o_record_end     (o_record_end)
    );

endmodule

// ===== hw/rtl/ihex_front.sv =====
// Character classifier: turns colons and hex digits into queue items, drops the rest.
`timescale 1ns / 1ps

module ihex_front (
    input  logic              i_valid,
    input  logic [7:0]        i_character,
    input  logic              i_queue_full,
    output logic              o_stall,
    output logic              o_push,
    output ihex_pkg::t_token  o_token
);

    ihex_pkg::t_digit w_digit;
    logic             w_colon;

    assign w_digit = ihex_pkg::hex_digit(i_character);
    assign w_colon = (i_character == ihex_pkg::CHAR_COLON);

    assign o_stall          = i_queue_full;
    assign o_push           = i_valid && !i_queue_full && (w_colon || w_digit.hit);
    assign o_token.is_colon = w_colon;
    assign o_token.nibble   = w_digit.nibble;

endmodule

// ===== hw/rtl/ihex_fifo.sv =====
// Short item queue between the classifier and the record sequencer.
`timescale 1ns / 1ps

module ihex_fifo #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ihex_pkg::t_token  i_token,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output ihex_pkg::t_token  o_token
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    ihex_pkg::t_token r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == FULL);
    assign o_valid = (r_count != '0);
    assign o_token = r_mem[r_rd_ptr];

    assign w_push = i_push && !o_full;
    assign w_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

endmodule

// ===== hw/rtl/ihex_back.sv =====
// Record sequencer: pairs digits into bytes, tracks record fields, registers results.
`timescale 1ns / 1ps

module ihex_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_token_valid,
    input  ihex_pkg::t_token  i_token,
    output logic              o_token_pop,
    input  logic              i_stall,
    output logic              o_valid,
    output logic [7:0]        o_byte_value,
    output logic [2:0]        o_field_kind,
    output logic [15:0]       o_record_address,
    output logic [7:0]        o_data_offset,
    output logic              o_checksum_ok,
    output logic              o_end_of_file,
    output logic              o_record_end
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_COUNT = 8'b0000_0010,
        S_AHI   = 8'b0000_0100,
        S_ALO   = 8'b0000_1000,
        S_TYPE  = 8'b0001_0000,
        S_DATA  = 8'b0010_0000,
        S_CSUM  = 8'b0100_0000,
        S_EOF   = 8'b1000_0000
    } t_state;

    t_state      r_state, n_state;
    logic        r_pending, n_pending;
    logic [3:0]  r_high, n_high;
    logic [7:0]  r_count, n_count;
    logic [7:0]  r_index, n_index;
    logic [7:0]  r_sum, n_sum;
    logic [15:0] r_addr, n_addr;
    logic [7:0]  r_type, n_type;

    logic        r_out_valid;
    logic [7:0]  r_byte;
    logic [2:0]  r_kind;
    logic [15:0] r_out_addr;
    logic [7:0]  r_offset;
    logic        r_ok, r_eof, r_end;

    logic        w_pop, w_load, w_emit;
    logic [7:0]  w_byte, w_sum, w_offset;
    logic [2:0]  w_kind;
    logic        w_ok, w_eof, w_end;

    // Output register frees up when empty or being taken this cycle.
    assign w_load      = !r_out_valid || !i_stall;
    assign w_pop       = i_token_valid && w_load;
    assign o_token_pop = w_pop;

    assign w_byte = {r_high, i_token.nibble};
    assign w_sum  = r_sum + w_byte;

    always_comb begin
        n_state   = r_state;
        n_pending = r_pending;
        n_high    = r_high;
        n_count   = r_count;
        n_index   = r_index;
        n_sum     = r_sum;
        n_addr    = r_addr;
        n_type    = r_type;
        w_emit    = 1'b0;
        w_kind    = ihex_pkg::KIND_COUNT;
        w_offset  = 8'h00;
        w_ok      = 1'b0;
        w_eof     = 1'b0;
        w_end     = 1'b0;
        if (w_pop && r_state != S_EOF) begin
            if (i_token.is_colon) begin
                // colon restarts the record, dropping any partial one
                n_state   = S_COUNT;
                n_pending = 1'b0;
                n_high    = 4'h0;
                n_count   = 8'h00;
                n_index   = 8'h00;
                n_sum     = 8'h00;
                n_addr    = 16'h0000;
                n_type    = 8'h00;
            end else if (r_state != S_IDLE) begin
                if (!r_pending) begin
                    n_high    = i_token.nibble;
                    n_pending = 1'b1;
                end else begin
                    n_pending = 1'b0;
                    n_high    = 4'h0;
                    n_sum     = w_sum;
                    w_emit    = 1'b1;
                    case (r_state)
                        S_COUNT: begin
                            w_kind  = ihex_pkg::KIND_COUNT;
                            n_count = w_byte;
                            n_state = S_AHI;
                        end
                        S_AHI: begin
                            w_kind  = ihex_pkg::KIND_ADDR_HI;
                            n_addr  = {w_byte, 8'h00};
                            n_state = S_ALO;
                        end
                        S_ALO: begin
                            w_kind  = ihex_pkg::KIND_ADDR_LO;
                            n_addr  = {r_addr[15:8], w_byte};
                            n_state = S_TYPE;
                        end
                        S_TYPE: begin
                            w_kind  = ihex_pkg::KIND_TYPE;
                            n_type  = w_byte;
                            n_index = 8'h00;
                            n_state = (r_count == 8'h00) ? S_CSUM : S_DATA;
                        end
                        S_DATA: begin
                            w_kind   = ihex_pkg::KIND_DATA;
                            w_offset = r_index;
                            n_index  = r_index + 8'd1;
                            if (n_index == r_count) begin
                                n_state = S_CSUM;
                            end
                        end
                        S_CSUM: begin
                            w_kind  = ihex_pkg::KIND_CHECKSUM;
                            w_end   = 1'b1;
                            w_ok    = (w_sum == 8'h00);
                            w_eof   = (r_count == 8'h00) && (r_addr == 16'h0000) &&
                                      (r_type == ihex_pkg::EOF_TYPE) &&
                                      (w_byte == ihex_pkg::EOF_CHECKSUM);
                            n_state = w_eof ? S_EOF : S_IDLE;
                        end
                        default: begin
                            w_emit  = 1'b0;
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pending   <= 1'b0;
            r_high      <= 4'h0;
            r_count     <= 8'h00;
            r_index     <= 8'h00;
            r_sum       <= 8'h00;
            r_addr      <= 16'h0000;
            r_type      <= 8'h00;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pending <= n_pending;
            r_high    <= n_high;
            r_count   <= n_count;
            r_index   <= n_index;
            r_sum     <= n_sum;
            r_addr    <= n_addr;
            r_type    <= n_type;
            if (w_load) begin
                r_out_valid <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && w_emit) begin
            r_byte     <= w_byte;
            r_kind     <= w_kind;
            r_out_addr <= n_addr;
            r_offset   <= w_offset;
            r_ok       <= w_ok;
            r_eof      <= w_eof;
            r_end      <= w_end;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_byte_value     = r_byte;
    assign o_field_kind     = r_kind;
    assign o_record_address = r_out_addr;
    assign o_data_offset    = r_offset;
    assign o_checksum_ok    = r_ok;
    assign o_end_of_file    = r_eof;
    assign o_record_end     = r_end;

endmodule

// ===== hw/rtl/ihex_checker.sv =====
// Port-level checks for the hex record decoder and their bind.
`timescale 1ns / 1ps
`include "intel_hex_record_decoder_defines.svh"

module ihex_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [7:0]  i_character,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_byte_value,
    input logic [2:0]  o_field_kind,
    input logic [15:0] o_record_address,
    input logic [7:0]  o_data_offset,
    input logic        o_checksum_ok,
    input logic        o_end_of_file,
    input logic        o_record_end
);

    // held result must not move while the receiver stalls
    `IHEX_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_byte_value) && $stable(o_field_kind) && $stable(o_record_address))

    // the last byte of a record is exactly the checksum field
    `IHEX_ASSERT_NOW(a_end_is_csum, o_valid, o_record_end == (o_field_kind == ihex_pkg::KIND_CHECKSUM))

    // checksum and end-of-file flags only on the closing byte
    `IHEX_ASSERT_NOW(a_flags_on_end, o_valid && (o_checksum_ok || o_end_of_file), o_record_end)

    // offsets belong to data bytes only
    `IHEX_ASSERT_NOW(a_offset_data, o_valid && (o_field_kind != ihex_pkg::KIND_DATA), o_data_offset == 8'h00)

    // nothing follows the end-of-file record
    `IHEX_ASSERT_NEXT(a_quiet_after_eof, o_valid && !i_stall && o_end_of_file, !o_valid)

endmodule

bind intel_hex_record_decoder ihex_checker u_checker (.*);
